// File: hw/rtl/bplc_pkg.sv
// Shared types and constants of the button press LED controller.
`timescale 1ns / 1ps

package bplc_pkg;

  // Event reported by the button machine for one tick.
  typedef enum logic [1:0] {
    EvNone    = 2'd0,
    EvShort   = 2'd1,
    EvLong    = 2'd2,
    EvRelease = 2'd3
  } press_event_e;

  // Mode of the LED machine.
  typedef enum logic [1:0] {
    ModeOff   = 2'd0,
    ModeOn    = 2'd1,
    ModeBlink = 2'd2
  } lamp_mode_e;

  // Configuration register indexes, taken from paddr[3:2].
  typedef enum logic [1:0] {
    RegDebounce  = 2'd0,
    RegLongPress = 2'd1,
    RegBlinkHalf = 2'd2
  } reg_index_e;

  localparam int unsigned CountWidth = 16;
  localparam int unsigned AddrWidth  = 4;
  localparam int unsigned DataWidth  = 32;

  localparam logic [CountWidth-1:0] DebounceReset  = 16'd20;
  localparam logic [CountWidth-1:0] LongPressReset = 16'd2000;
  localparam logic [CountWidth-1:0] BlinkHalfReset = 16'd330;

endpackage

// File: hw/rtl/button_press_led_controller_unit.sv
// Button debounce, long-press detector and LED mode controller, top level.
`timescale 1ns / 1ps

// Channel     | Direction | Handshake               | Payload
// ------------+-----------+-------------------------+--------------------------------------
// input tick  | in        | in_valid_i / in_stall_o | raw_pressed_i
// result      | out       | out_valid_o/out_stall_i | press_event_o, led_drive_o,
//             |           |                         | led_mode_o, level_indicator_o
// config      | in        | APB psel/penable/pready | paddr, pwdata, prdata
//
// For every tick, the button machine, the LED machine and the blink timer are
// evaluated in one short pass of logic from the state registers, and the result
// lands in the output register at the edge that accepts the tick.
// A new tick is accepted in every cycle while the output register is empty or is
// being drained in the same cycle, so the sustained rate is one tick per cycle.
// When the result is stalled, in_stall_o is raised and the state is held.
// Reset (rst_ni low) returns the machines to idle and off, clears all counters
// and loads the default thresholds of 20, 2000 and 330 ticks.

module button_press_led_controller_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Input tick channel.
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                raw_pressed_i,
  // Result channel.
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output bplc_pkg::press_event_e              press_event_o,
  output logic                                led_drive_o,
  output bplc_pkg::lamp_mode_e                led_mode_o,
  output logic                                level_indicator_o,
  // Configuration port.
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bplc_pkg::AddrWidth-1:0]      paddr,
  input  logic [bplc_pkg::DataWidth-1:0]      pwdata,
  output logic [bplc_pkg::DataWidth-1:0]      prdata,
  output logic                                pready
);

  import bplc_pkg::*;

  // Phases of the button machine.
  typedef enum logic [1:0] {
    PhIdle     = 2'd0,
    PhDebounce = 2'd1,
    PhPressed  = 2'd2,
    PhLong     = 2'd3
  } phase_e;

  // Configuration registers.
  logic [CountWidth-1:0] debounce_ticks_q;
  logic [CountWidth-1:0] long_press_ticks_q;
  logic [CountWidth-1:0] blink_half_q;

  // Machine state.
  phase_e                phase_q, phase_d;
  logic [CountWidth-1:0] debounce_cnt_q, debounce_cnt_d;
  logic [CountWidth-1:0] press_cnt_q, press_cnt_d;
  lamp_mode_e            mode_q, mode_d;
  logic [CountWidth-1:0] blink_cnt_q, blink_cnt_d;
  logic                  blink_phase_q, blink_phase_d;
  logic                  lamp_level_q, lamp_level_d;

  // Result register.
  logic                  out_valid_q;
  press_event_e          event_q;
  logic                  led_drive_q;
  lamp_mode_e            led_mode_q;
  logic                  level_q;

  press_event_e          event_d;
  logic [CountWidth-1:0] blink_base;
  logic                  in_accept;
  logic                  cfg_write;
  reg_index_e            cfg_index;

  // A tick may enter whenever the result register is free or drains this cycle.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = reg_index_e'(paddr[3:2]);

  always_comb begin
    unique case (cfg_index)
      RegDebounce:  prdata = {{(DataWidth-CountWidth){1'b0}}, debounce_ticks_q};
      RegLongPress: prdata = {{(DataWidth-CountWidth){1'b0}}, long_press_ticks_q};
      RegBlinkHalf: prdata = {{(DataWidth-CountWidth){1'b0}}, blink_half_q};
      default:      prdata = '0;
    endcase
  end

  // Button machine. The debounce count is advanced before the level is
  // checked, and the press count only while the button stays down.
  always_comb begin
    phase_d        = phase_q;
    debounce_cnt_d = debounce_cnt_q;
    press_cnt_d    = press_cnt_q;
    event_d        = EvNone;
    unique case (phase_q)
      PhIdle: begin
        if (raw_pressed_i) begin
          phase_d        = PhDebounce;
          debounce_cnt_d = '0;
        end
      end
      PhDebounce: begin
        debounce_cnt_d = debounce_cnt_q + 16'd1;
        if (!raw_pressed_i) begin
          phase_d = PhIdle;
        end else if (debounce_cnt_d >= debounce_ticks_q) begin
          phase_d     = PhPressed;
          press_cnt_d = '0;
        end
      end
      PhPressed: begin
        if (!raw_pressed_i) begin
          event_d = EvShort;
          phase_d = PhIdle;
        end else begin
          press_cnt_d = press_cnt_q + 16'd1;
          if (press_cnt_d >= long_press_ticks_q) begin
            event_d = EvLong;
            phase_d = PhLong;
          end
        end
      end
      PhLong: begin
        if (!raw_pressed_i) begin
          event_d = EvRelease;
          phase_d = PhIdle;
        end
      end
      default: begin
        phase_d = PhIdle;
      end
    endcase
  end

  // LED machine, then the blink timer, which sees the mode left by the event.
  // A short press while blinking turns the LED off but keeps the blink phase.
  always_comb begin
    mode_d        = mode_q;
    lamp_level_d  = lamp_level_q;
    blink_phase_d = blink_phase_q;
    blink_base    = blink_cnt_q;
    case (event_d)
      EvShort: begin
        if (mode_q == ModeOff) begin
          mode_d       = ModeOn;
          lamp_level_d = 1'b1;
        end else begin
          mode_d       = ModeOff;
          lamp_level_d = 1'b0;
        end
      end
      EvLong: begin
        mode_d        = ModeBlink;
        blink_base    = '0;
        blink_phase_d = 1'b1;
        lamp_level_d  = 1'b1;
      end
      default: begin
      end
    endcase

    blink_cnt_d = blink_base;
    if (mode_d == ModeBlink) begin
      blink_cnt_d = blink_base + 16'd1;
      if (blink_cnt_d >= blink_half_q) begin
        blink_cnt_d   = '0;
        blink_phase_d = !blink_phase_d;
        lamp_level_d  = blink_phase_d;
      end
    end
  end

  // Configuration registers; a write beyond the list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_ticks_q   <= DebounceReset;
      long_press_ticks_q <= LongPressReset;
      blink_half_q       <= BlinkHalfReset;
    end else if (cfg_write) begin
      unique case (cfg_index)
        RegDebounce:  debounce_ticks_q   <= pwdata[CountWidth-1:0];
        RegLongPress: long_press_ticks_q <= pwdata[CountWidth-1:0];
        RegBlinkHalf: blink_half_q       <= pwdata[CountWidth-1:0];
        default: begin
        end
      endcase
    end
  end

  // Machine state advances only on an accepted tick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PhIdle;
      debounce_cnt_q <= '0;
      press_cnt_q    <= '0;
      mode_q         <= ModeOff;
      blink_cnt_q    <= '0;
      blink_phase_q  <= 1'b0;
      lamp_level_q   <= 1'b0;
    end else if (in_accept) begin
      phase_q        <= phase_d;
      debounce_cnt_q <= debounce_cnt_d;
      press_cnt_q    <= press_cnt_d;
      mode_q         <= mode_d;
      blink_cnt_q    <= blink_cnt_d;
      blink_phase_q  <= blink_phase_d;
      lamp_level_q   <= lamp_level_d;
    end
  end

  // Result register: filled by an accepted tick, emptied by a transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= in_accept || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      event_q     <= event_d;
      led_drive_q <= lamp_level_d;
      led_mode_q  <= mode_d;
      level_q     <= raw_pressed_i;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign press_event_o     = event_q;
  assign led_drive_o       = led_drive_q;
  assign led_mode_o        = led_mode_q;
  assign level_indicator_o = level_q;

  // An accepted tick always leaves a result waiting in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> out_valid_q)
    else $error("accepted tick produced no result");

  // The LED is dark when off and lit when steadily on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == ModeOff |-> !lamp_level_q) and (mode_q == ModeOn |-> lamp_level_q))
    else $error("LED level disagrees with its mode");

  // A reported long press always comes with blink mode.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && event_q == EvLong) |-> led_mode_q == ModeBlink)
    else $error("long press reported outside blink mode");

  // After a long press the button machine can only return to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && phase_q == PhLong && phase_d != PhLong) |-> phase_d == PhIdle)
    else $error("button machine left the long phase wrongly");

endmodule
